// File: design/wbps_pkg.sv
// Package with shared constants, codes and types of the wildcard byte pattern search.
`default_nettype none
package wbps_pkg;

  // Default depth of the pattern store and of the byte history line.
  localparam int unsigned PATTERN_MAX = 256;
  // Number of cell hit bits combined by one register of the reduction tree.
  localparam int unsigned GROUP_SIZE = 16;

  localparam int unsigned LEN_W  = 9;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OFS_W  = 32;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;

  // Transaction kinds on the input channel.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_SCAN = 1'b1;

  // Register index, taken from paddr[2].
  localparam logic REG_PATTERN_LENGTH = 1'b0;

  // Saturation value of the byte counter.
  localparam logic [OFS_W-1:0] OFS_MAX = '1;

  // Controls that the top level broadcasts to every cell.
  typedef struct packed {
    logic shift;   // a scan byte enters the history line
    logic rotate;  // the pattern ring moves one cell up
    logic adv;     // the compare stage may take a new result
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: design/wbps_cell.sv
// One search cell: a pattern entry, one history byte and a registered compare result.
`default_nettype none
module wbps_cell (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire wbps_pkg::cell_ctrl_t ctrl_i,
  input  wire                      active_i,
  input  wire                      wr_i,
  input  wire [wbps_pkg::LEN_W-1:0]  wr_data_i,
  input  wire [wbps_pkg::BYTE_W-1:0] h_prev_i,
  input  wire [wbps_pkg::LEN_W-1:0]  q_prev_i,
  output logic [wbps_pkg::BYTE_W-1:0] h_o,
  output logic [wbps_pkg::LEN_W-1:0]  q_o,
  output logic                        hit_o
);
  import wbps_pkg::*;

  logic [BYTE_W-1:0] h_q, h_d;
  logic [LEN_W-1:0]  q_q, q_d;
  logic              hit_q, hit_d;

  // Bit 8 of an entry marks a wildcard.
  always_comb begin
    h_d = ctrl_i.shift ? h_prev_i : h_q;
    if (ctrl_i.rotate) begin
      q_d = q_prev_i;
    end else if (wr_i) begin
      q_d = wr_data_i;
    end else begin
      q_d = q_q;
    end
    hit_d = !active_i || q_q[LEN_W-1] || (q_q[BYTE_W-1:0] == h_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q   <= '0;
      hit_q <= 1'b0;
    end else begin
      h_q <= h_d;
      if (ctrl_i.adv) begin
        hit_q <= hit_d;
      end
    end
  end

  // The pattern entry is undefined until written and has no reset.
  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign h_o   = h_q;
  assign q_o   = q_q;
  assign hit_o = hit_q;

endmodule
`default_nettype wire

// File: design/wbps_tail.sv
// Final stage: region bookkeeping, match decision and the result register.
`default_nettype none
module wbps_tail #(
  parameter int unsigned EnW = 9
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       v_i,
  input  wire                       first_i,
  input  wire                       last_i,
  input  wire                       all_hit_i,
  input  wire [EnW-1:0]             en_i,
  input  wire                       out_stall_i,
  output logic                      out_valid_o,
  output logic                      found_o,
  output logic [wbps_pkg::OFS_W-1:0] match_offset_o,
  output logic                      hold_o
);
  import wbps_pkg::*;

  logic             done_q, done_d;
  logic [OFS_W-1:0] cnt_q, cnt_d;
  logic [OFS_W-1:0] cnt_inc;
  logic [OFS_W:0]   diff;
  logic             live, ge, hit, res;
  logic             ov_q, ov_d;
  logic             fnd_q, fnd_d;
  logic [OFS_W-1:0] ofs_q, ofs_d;

  always_comb begin
    cnt_inc = (cnt_q == OFS_MAX) ? cnt_q : cnt_q + OFS_W'(1);
    cnt_d   = first_i ? OFS_W'(1) : cnt_inc;
    live    = v_i && (first_i || !done_q);
    diff    = {1'b0, cnt_d} - (OFS_W + 1)'(en_i);
    ge      = !diff[OFS_W];
    hit     = live && ge && all_hit_i;
    res     = live && (hit || last_i);
    hold_o  = ov_q && out_stall_i && res;
  end

  always_comb begin
    done_d = done_q;
    ov_d   = ov_q;
    fnd_d  = fnd_q;
    ofs_d  = ofs_q;
    if (!hold_o) begin
      if (live) begin
        done_d = res;
      end
      if (res) begin
        ov_d  = 1'b1;
        fnd_d = hit;
        ofs_d = hit ? diff[OFS_W-1:0] : '0;
      end else if (ov_q && !out_stall_i) begin
        ov_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b1;
      cnt_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      done_q <= done_d;
      ov_q   <= ov_d;
      if (!hold_o && live) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fnd_q <= fnd_d;
    ofs_q <= ofs_d;
  end

  assign out_valid_o    = ov_q;
  assign found_o        = fnd_q;
  assign match_offset_o = ofs_q;

endmodule
`default_nettype wire

// File: design/wildcard_byte_pattern_search_top.sv
// Top level of the wildcard byte pattern search: cell row, compare pipeline and APB register.
//
//   channel | direction | handshake                   | payload
//   --------+-----------+-----------------------------+------------------------------------------
//   input   | in        | in_valid_i / in_stall_o     | kind, pattern_index, byte_value,
//           |           |                             | wildcard_req, first, last
//   output  | out       | out_valid_o / out_stall_i   | found, match_offset
//   config  | in        | psel, penable, pready (APB) | pattern_length at byte address 0
//
// One transaction is accepted per cycle while in_stall_o is low. A scan byte shifts into the
// history at the edge that accepts it; the cell compare, the group AND and the final decision
// are each registered after it, the last in the result register.
// After a pattern_length write the pattern ring rotates one cell per cycle until it is
// aligned to the new length, and in_stall_o stays high.
// Reset clears the control state and the history; no clearing pass is needed.
// in_stall_o also rises while a stalled result sits in the output register and another
// result reaches the final stage.
`default_nettype none
module wildcard_byte_pattern_search_top #(
  parameter int unsigned PatternMax = wbps_pkg::PATTERN_MAX
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // Input channel.
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire                          kind_i,
  input  wire [7:0]                    pattern_index_i,
  input  wire [7:0]                    byte_value_i,
  input  wire                          wildcard_req_i,
  input  wire                          first_i,
  input  wire                          last_i,
  // Output channel.
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         found_o,
  output logic [31:0]                  match_offset_o,
  // Configuration port.
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [wbps_pkg::APB_AW-1:0]   paddr,
  input  wire [wbps_pkg::APB_DW-1:0]   pwdata,
  output logic [wbps_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import wbps_pkg::*;

  localparam int unsigned IdxW   = (PatternMax > 1) ? $clog2(PatternMax) : 1;
  localparam int unsigned EnW    = $clog2(PatternMax + 1);
  localparam int unsigned SumW   = ((IdxW > BYTE_W) ? IdxW : BYTE_W) + 2;
  localparam int unsigned NumGrp = (PatternMax + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int unsigned ClampW = (EnW > LEN_W) ? EnW : LEN_W;

  // The pattern is held as a ring: cell k holds entry (align - 1 - k) mod PatternMax,
  // while cell k of the history line holds the byte of age k. With align equal to the
  // effective length, cell k compares exactly the pair that the search needs.
  logic [LEN_W-1:0] len_q;
  logic [EnW-1:0]   en_q, en_new;
  logic [EnW-1:0]   align_q, align_d;
  logic [ClampW-1:0] len_v;
  logic             cfg_wr;
  logic             rotating;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PATTERN_LENGTH);
  assign prdata = (paddr[2] == REG_PATTERN_LENGTH) ?
                  {{(APB_DW - LEN_W){1'b0}}, len_q} : '0;

  // A length of zero acts as one, and lengths above the store depth are clipped.
  always_comb begin
    len_v = ClampW'(pwdata[LEN_W-1:0]);
    if (len_v == '0) begin
      en_new = EnW'(1);
    end else if (len_v > ClampW'(PatternMax)) begin
      en_new = EnW'(PatternMax);
    end else begin
      en_new = len_v[EnW-1:0];
    end
  end

  assign rotating = (align_q != en_q);
  assign align_d  = (align_q == EnW'(PatternMax)) ? EnW'(1) : align_q + EnW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= LEN_W'(1);
      en_q    <= EnW'(1);
      align_q <= EnW'(1);
    end else begin
      if (cfg_wr) begin
        len_q <= pwdata[LEN_W-1:0];
        en_q  <= en_new;
      end
      if (rotating) begin
        align_q <= align_d;
      end
    end
  end

  // Input handshake. The pipeline freezes only when the final stage has a result and the
  // output register is full and stalled.
  logic hold, adv;
  logic in_acc, scan_acc, load_acc;

  assign adv        = !hold;
  assign in_stall_o = hold || rotating;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign scan_acc   = in_acc && (kind_i == KIND_SCAN);
  assign load_acc   = in_acc && (kind_i == KIND_LOAD) &&
                      (SumW'(pattern_index_i) < SumW'(PatternMax));

  // Cell that a pattern write lands in.
  logic [SumW-1:0] wsum;
  logic [IdxW-1:0] widx;

  always_comb begin
    wsum = SumW'(align_q - EnW'(1)) + SumW'(PatternMax) - SumW'(pattern_index_i);
    if (wsum >= SumW'(PatternMax)) begin
      wsum = wsum - SumW'(PatternMax);
    end
    widx = wsum[IdxW-1:0];
  end

  // Stage registers that travel with each scan transaction.
  logic           v1_q, v2_q, v3_q;
  logic           first1_q, first2_q, first3_q;
  logic           last1_q, last2_q, last3_q;
  logic [EnW-1:0] en1_q, en2_q, en3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= scan_acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      first1_q <= first_i;
      last1_q  <= last_i;
      en1_q    <= en_q;
      first2_q <= first1_q;
      last2_q  <= last1_q;
      en2_q    <= en1_q;
      first3_q <= first2_q;
      last3_q  <= last2_q;
      en3_q    <= en2_q;
    end
  end

  // Row of cells.
  cell_ctrl_t       ctrl;
  logic [BYTE_W-1:0] h   [PatternMax];
  logic [LEN_W-1:0]  q   [PatternMax];
  logic [PatternMax-1:0] hit;
  logic [LEN_W-1:0]  wr_data;

  assign ctrl    = '{shift: scan_acc, rotate: rotating, adv: adv};
  assign wr_data = {wildcard_req_i, byte_value_i};

  for (genvar k = 0; k < PatternMax; k++) begin : g_cell
    logic [BYTE_W-1:0] h_prev;
    logic [LEN_W-1:0]  q_prev;
    logic              active;
    logic              wsel;

    if (k == 0) begin : g_head
      assign h_prev = byte_value_i;
      assign q_prev = q[PatternMax-1];
    end else begin : g_body
      assign h_prev = h[k-1];
      assign q_prev = q[k-1];
    end

    assign active = (EnW'(k) < en1_q);
    assign wsel   = load_acc && (widx == IdxW'(k));

    wbps_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .active_i  (active),
      .wr_i      (wsel),
      .wr_data_i (wr_data),
      .h_prev_i  (h_prev),
      .q_prev_i  (q_prev),
      .h_o       (h[k]),
      .q_o       (q[k]),
      .hit_o     (hit[k])
    );
  end

  // First level of the AND tree over the cell hits.
  logic [NumGrp-1:0] grp_q, grp_d;

  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      grp_d[g] = 1'b1;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (g * GROUP_SIZE + j < PatternMax) begin
          grp_d[g] = grp_d[g] & hit[g * GROUP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= '0;
    end else if (adv) begin
      grp_q <= grp_d;
    end
  end

  wbps_tail #(
    .EnW (EnW)
  ) u_tail (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .v_i            (v3_q),
    .first_i        (first3_q),
    .last_i         (last3_q),
    .all_hit_i      (&grp_q),
    .en_i           (en3_q),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .found_o        (found_o),
    .match_offset_o (match_offset_o),
    .hold_o         (hold)
  );

endmodule
`default_nettype wire

// File: design/wbps_checker.sv
// Port-level checker for the wildcard byte pattern search, bound to the top level.
`default_nettype none
module wbps_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          out_valid_o,
  input wire                          out_stall_i,
  input wire                          found_o,
  input wire [31:0]                   match_offset_o,
  input wire                          psel,
  input wire                          penable,
  input wire                          pwrite,
  input wire [wbps_pkg::APB_AW-1:0]   paddr,
  input wire [wbps_pkg::APB_DW-1:0]   pwdata,
  input wire [wbps_pkg::APB_DW-1:0]   prdata
);
  import wbps_pkg::*;

  // A stalled result transaction keeps its payload.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(found_o) && $stable(match_offset_o))
    else $error("result changed while stalled");

  // A not-found result always carries a zero offset.
  a_nf_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> match_offset_o == '0)
    else $error("not-found result with nonzero offset");

  // The length register reads back what was last written to it.
  a_readback : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr == '0) ##1 (paddr == '0) |->
      prdata == {{(APB_DW - LEN_W){1'b0}}, $past(pwdata[LEN_W-1:0])})
    else $error("pattern_length readback mismatch");

endmodule

bind wildcard_byte_pattern_search_top wbps_checker u_wbps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .found_o        (found_o),
  .match_offset_o (match_offset_o),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata)
);
`default_nettype wire
